// ===== hw/rtl/kfd_pkg.sv =====
`timescale 1ns / 1ps

package kfd_pkg;

    // kiss framing bytes
    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_START   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_COMMAND_BYTE  = 2'd0;
    localparam logic [1:0] CFG_HEADER_LENGTH = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RST_COMMAND_BYTE  = 8'h00;
    localparam logic [3:0]  RST_HEADER_LENGTH = 4'd6;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] status;
    } out_item_t;

    // class of one request, decided by the front part
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_FEND,
        KIND_FESC,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       cmd_match;
        logic [7:0] raw_byte;
        logic [7:0] esc_byte;
    } cls_item_t;

    // queue fill status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HUNT_FEND,
        PH_HEADER,
        PH_DATA,
        PH_DATA_ESC
    } phase_t;

endpackage

// ===== hw/rtl/kfd_front.sv =====
`timescale 1ns / 1ps

module kfd_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  kfd_pkg::in_item_t  in_item,
    input  logic [7:0]         command_byte,
    input  kfd_pkg::q_stat_t   q_stat,
    output logic               push,
    output kfd_pkg::cls_item_t entry
);

    // take a request whenever the queue has room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify the request
    always_comb
    begin
        entry.raw_byte  = in_item.rx_byte;
        entry.cmd_match = (in_item.rx_byte == command_byte);
        if (in_item.op == kfd_pkg::OP_TICK)
        begin
            entry.kind = kfd_pkg::KIND_TICK;
        end
        else if (in_item.rx_byte == kfd_pkg::KISS_FEND)
        begin
            entry.kind = kfd_pkg::KIND_FEND;
        end
        else if (in_item.rx_byte == kfd_pkg::KISS_FESC)
        begin
            entry.kind = kfd_pkg::KIND_FESC;
        end
        else
        begin
            entry.kind = kfd_pkg::KIND_OTHER;
        end

        // byte as it reads after an escape
        if (in_item.rx_byte == kfd_pkg::KISS_TFEND)
        begin
            entry.esc_byte = kfd_pkg::KISS_FEND;
        end
        else if (in_item.rx_byte == kfd_pkg::KISS_TFESC)
        begin
            entry.esc_byte = kfd_pkg::KISS_FESC;
        end
        else
        begin
            entry.esc_byte = in_item.rx_byte;
        end
    end

endmodule

// ===== hw/rtl/kfd_queue.sv =====
`timescale 1ns / 1ps

module kfd_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kfd_pkg::cls_item_t push_entry,
    input  logic               pop,
    output kfd_pkg::cls_item_t head_entry,
    output kfd_pkg::q_stat_t   q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    kfd_pkg::cls_item_t data_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign head_entry   = data_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/kfd_back.sv =====
`timescale 1ns / 1ps

module kfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  kfd_pkg::cls_item_t head_entry,
    input  kfd_pkg::q_stat_t   q_stat,
    output logic               pop,
    input  logic [3:0]         header_length,
    input  logic [15:0]        timeout_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output kfd_pkg::out_item_t out_item
);

    kfd_pkg::phase_t    phase_reg;
    kfd_pkg::phase_t    phase_next;
    logic [3:0]         header_left_reg;
    logic [3:0]         header_left_next;
    logic [15:0]        idle_count_reg;
    logic [15:0]        idle_count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    kfd_pkg::out_item_t out_item_reg;
    kfd_pkg::out_item_t out_item_next;
    logic               emit;
    kfd_pkg::out_item_t result;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // advance when the output register is free or being drained
    assign pop = !q_stat.empty && (!out_valid_reg || !out_stall);

    // deframing state machine
    always_comb
    begin
        phase_next          = phase_reg;
        header_left_next    = header_left_reg;
        idle_count_next     = idle_count_reg;
        emit                = 1'b0;
        result.payload_byte = 8'h00;
        result.status       = kfd_pkg::ST_DATA;

        if (head_entry.kind == kfd_pkg::KIND_TICK)
        begin
            if (idle_count_reg < timeout_ticks)
            begin
                idle_count_next = idle_count_reg + 16'd1;
            end
            else
            begin
                idle_count_next  = '0;
                phase_next       = kfd_pkg::PH_HUNT;
                header_left_next = '0;
                if (phase_reg == kfd_pkg::PH_DATA || phase_reg == kfd_pkg::PH_DATA_ESC)
                begin
                    emit          = 1'b1;
                    result.status = kfd_pkg::ST_TIMEOUT;
                end
            end
        end
        else
        begin
            idle_count_next = '0;
            case (phase_reg)
                kfd_pkg::PH_HUNT,
                kfd_pkg::PH_HUNT_FEND:
                begin
                    if (head_entry.kind == kfd_pkg::KIND_FEND)
                    begin
                        phase_next = kfd_pkg::PH_HUNT_FEND;
                    end
                    else if (phase_reg == kfd_pkg::PH_HUNT_FEND && head_entry.cmd_match)
                    begin
                        if (header_length == 4'd0)
                        begin
                            phase_next    = kfd_pkg::PH_DATA;
                            emit          = 1'b1;
                            result.status = kfd_pkg::ST_START;
                        end
                        else
                        begin
                            header_left_next = header_length;
                            phase_next       = kfd_pkg::PH_HEADER;
                        end
                    end
                    else
                    begin
                        phase_next = kfd_pkg::PH_HUNT;
                    end
                end
                kfd_pkg::PH_HEADER:
                begin
                    header_left_next = header_left_reg - 4'd1;
                    if (header_left_reg == 4'd1)
                    begin
                        phase_next    = kfd_pkg::PH_DATA;
                        emit          = 1'b1;
                        result.status = kfd_pkg::ST_START;
                    end
                end
                kfd_pkg::PH_DATA:
                begin
                    if (head_entry.kind == kfd_pkg::KIND_FEND)
                    begin
                        phase_next    = kfd_pkg::PH_HUNT;
                        emit          = 1'b1;
                        result.status = kfd_pkg::ST_END;
                    end
                    else if (head_entry.kind == kfd_pkg::KIND_FESC)
                    begin
                        phase_next = kfd_pkg::PH_DATA_ESC;
                    end
                    else
                    begin
                        emit                = 1'b1;
                        result.payload_byte = head_entry.raw_byte;
                    end
                end
                kfd_pkg::PH_DATA_ESC:
                begin
                    if (head_entry.kind == kfd_pkg::KIND_FEND)
                    begin
                        phase_next    = kfd_pkg::PH_HUNT;
                        emit          = 1'b1;
                        result.status = kfd_pkg::ST_END;
                    end
                    else
                    begin
                        phase_next          = kfd_pkg::PH_DATA;
                        emit                = 1'b1;
                        result.payload_byte = head_entry.esc_byte;
                    end
                end
                default:
                begin
                    phase_next       = kfd_pkg::PH_HUNT;
                    header_left_next = '0;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (pop)
        begin
            out_valid_next = emit;
            out_item_next  = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= kfd_pkg::PH_HUNT;
            header_left_reg <= '0;
            idle_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                header_left_reg <= header_left_next;
                idle_count_reg  <= idle_count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

// ===== hw/rtl/kiss_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        input      in_valid / in_stall    in_item  (op, rx_byte)
// out       output     out_valid / out_stall  out_item (payload_byte, status)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one request per cycle sustained while the output is not stalled; a result passes
// through the classify queue and then the output register before it appears.
// throughput is set by the deframing state machine in the back part.
// reset clears the state machine, idle counter, queue, out_valid and config registers.
// a stalled output holds its result; the queue keeps taking requests until it fills.

module kiss_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  kfd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output kfd_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [7:0]         command_byte_reg;
    logic [3:0]         header_length_reg;
    logic [15:0]        timeout_ticks_reg;
    logic               push;
    logic               pop;
    kfd_pkg::cls_item_t push_entry;
    kfd_pkg::cls_item_t head_entry;
    kfd_pkg::q_stat_t   q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_byte_reg  <= kfd_pkg::RST_COMMAND_BYTE;
            header_length_reg <= kfd_pkg::RST_HEADER_LENGTH;
            timeout_ticks_reg <= kfd_pkg::RST_TIMEOUT_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kfd_pkg::CFG_COMMAND_BYTE:  command_byte_reg  <= cfg_data[7:0];
                kfd_pkg::CFG_HEADER_LENGTH: header_length_reg <= cfg_data[3:0];
                kfd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // classify side
    kfd_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .command_byte (command_byte_reg),
        .q_stat       (q_stat),
        .push         (push),
        .entry        (push_entry)
    );

    kfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    // deframing side
    kfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .q_stat        (q_stat),
        .pop           (pop),
        .header_length (header_length_reg),
        .timeout_ticks (timeout_ticks_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

    // never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // an empty queue always has room
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.empty |-> !in_stall)
        else $error("stall with empty queue");

    // control results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != kfd_pkg::ST_DATA) |-> (out_item.payload_byte == 8'h00))
        else $error("nonzero byte on control result");

    // a push into an empty queue leaves it non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_stat.empty) |=> !q_stat.empty)
        else $error("push lost");

endmodule
